### src/multiview_depth_layer_hint_defines.svh
// Assertion helpers shared by the RTL.
`ifndef MULTIVIEW_DEPTH_LAYER_HINT_DEFINES_SVH
`define MULTIVIEW_DEPTH_LAYER_HINT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MDLH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define MDLH_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

### src/mdlh_pkg.sv
`timescale 1ns / 1ps
package mdlh_pkg;

  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned QBITS    = 41;

  localparam logic [14:0] RATIO_MIN = 15'd328;
  localparam logic [14:0] RATIO_MAX = 15'd16384;

  typedef enum logic [1:0] {
    CFG_MIN_SOURCES  = 2'd0,
    CFG_MIN_SECTORS  = 2'd1,
    CFG_MAX_SPREAD   = 2'd2,
    CFG_RADIUS_RATIO = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PIX_NOT_RESIDUAL = 3'd0,
    PIX_FEW_SOURCES  = 3'd1,
    PIX_SPREAD_REJ   = 3'd2,
    PIX_FEW_SECTORS  = 3'd3,
    PIX_COVERED      = 3'd4
  } pix_status_e;

  function automatic logic [3:0] popcount8(input logic [7:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(x[i]);
    end
    return c;
  endfunction

endpackage

### src/mdlh_ifs.sv
`timescale 1ns / 1ps
interface mdlh_obs_if;
  logic        valid;
  logic        ready;
  logic [31:0] obs_depth;
  logic [2:0]  obs_sector;
  logic        in_residual;
  logic        obs_last;

  modport source (output valid, obs_depth, obs_sector, in_residual, obs_last, input ready);
  modport sink   (input valid, obs_depth, obs_sector, in_residual, obs_last, output ready);
endinterface

interface mdlh_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pixel_status;
  logic [31:0] hint_depth;
  logic [31:0] hint_radius;
  logic [4:0]  layer_sources;
  logic [3:0]  layer_sectors;

  modport source (output valid, pixel_status, hint_depth, hint_radius, layer_sources,
                  layer_sectors, input ready);
  modport sink   (input valid, pixel_status, hint_depth, hint_radius, layer_sources,
                  layer_sectors, output ready);
endinterface

### src/mdlh_div.sv
`timescale 1ns / 1ps
module mdlh_div import mdlh_pkg::*; #(
  parameter int unsigned NW = 106,
  parameter int unsigned DW = 74
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QBITS-1:0] quot_o
);

  localparam int unsigned STW = $clog2(QBITS + 1);

  logic [DW-1:0]    rem_q, den_q;
  logic [QBITS-1:0] low_q, quot_q;
  logic [STW-1:0]   step_q;
  logic             done_q;
  logic [DW:0]      trial, diff;
  logic             ge;

  // restoring long division, one quotient bit per cycle
  assign trial = {rem_q, low_q[QBITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= STW'(QBITS);
      done_q <= 1'b0;
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
      done_q <= (step_q == STW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DW'(num_i >> QBITS);
      low_q  <= num_i[QBITS-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (step_q != '0) begin
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_q  <= {low_q[QBITS-2:0], 1'b0};
      quot_q <= {quot_q[QBITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/multiview_depth_layer_hint.sv
// Multiview depth layer hint.
// obs_i carries one source observation per item; the item with obs_last set
// closes the pixel and is answered by exactly one item on res_o. Other items
// give no result. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce. A nonzero depth takes a reciprocal in
// the shared divider, then a sorted insert; a zero depth, or one beyond
// MAX_SOURCES, is not stored. On the last item of a residual pixel with
// enough sources, every window of the n sorted observations is visited; a
// window long enough to be scored takes three passes of the shared 32x32
// multiplier, a shift-add count multiply and, if the spread term is nonzero,
// the shared divider. A selected layer then gets the hint division and
// radius multiply. obs_i.ready is low for all of that work.
// The result is held on res_o until taken; a stalled receiver stalls the
// block, and no new item is accepted until the result goes.
// Reset returns the registers to 2, 2, 13, 655 and empties the observation
// list; the list storage itself is not cleared.
`timescale 1ns / 1ps
`include "multiview_depth_layer_hint_defines.svh"
module multiview_depth_layer_hint import mdlh_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdlh_obs_if.sink    obs_i,
  mdlh_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned CW  = $clog2(MAX_SOURCES + 1);
  localparam int unsigned IW  = $clog2(MAX_SOURCES);
  localparam int unsigned SW  = 32 + CW;
  localparam int unsigned QW  = 64 + CW;
  localparam int unsigned NQW = 64 + 2 * CW;
  localparam int unsigned S2W = 2 * SW;
  localparam int unsigned NW  = NQW + 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RCP, ST_RCP_W, ST_INS, ST_FIN, ST_LIM, ST_LIM_W, ST_RD, ST_SQ,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_NQ, ST_CMP, ST_DIV_W, ST_EVAL, ST_NEXT,
    ST_SEL, ST_HNT_W, ST_RAD, ST_RAD_W, ST_OUT
  } state_e;

  state_e state_q;

  logic [DEPTH_W-1:0]  inv_q [MAX_SOURCES];
  logic [SECTOR_W-1:0] sec_q [MAX_SOURCES];
  logic [CW-1:0]       cnt_q;

  logic [4:0]  min_src_q;
  logic [3:0]  min_sec_q;
  logic [15:0] max_spr_q;
  logic [14:0] ratio_q;

  logic [31:0]         dep_q;
  logic [SECTOR_W-1:0] osec_q;
  logic                resid_q, last_q;
  logic [31:0]         rcp_q;

  logic [CW-1:0]    n_q, mp_q, best_cnt_q;
  logic [IW-1:0]    b_q, e_q, best_b_q;
  logic [SW-1:0]    s_q, best_s_q;
  logic [QW-1:0]    q_q;
  logic [7:0]       mask_q, best_mask_q;
  logic [S2W-1:0]   s2_q;
  logic [NQW-1:0]   nq_q, mc_q;
  logic [QBITS-1:0] score_q, best_score_q;
  logic [47:0]      limit_q;
  logic             amb_q;
  logic [63:0]      prod_q;

  pix_status_e status_q;
  logic [31:0] hint_q, rad_q;
  logic [4:0]  srcs_q;
  logic [3:0]  secs_q;

  logic [31:0]         mul_a, mul_b;
  logic                div_start, div_done;
  logic [NW-1:0]       div_num;
  logic [S2W-1:0]      div_den;
  logic [QBITS-1:0]    div_quot;
  logic [31:0]         quot_sat;
  logic [DEPTH_W-1:0]  rd_v;
  logic [SECTOR_W-1:0] rd_sec;
  logic [4:0]          msrc;
  logic [3:0]          msec;
  logic [14:0]         ratio_c;
  logic [CW-1:0]       win_cnt;
  logic [31:0]         sh32, sl32;
  logic                obs_ready, res_valid, obs_acc;
  logic [NQW-1:0]      nq_diff;

  assign msrc    = (min_src_q < 5'd2) ? 5'd2 : min_src_q;
  assign msec    = (min_sec_q < 4'd2) ? 4'd2 : min_sec_q;
  assign ratio_c = (ratio_q < RATIO_MIN) ? RATIO_MIN :
                   ((ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q);
  assign win_cnt = CW'(e_q) - CW'(b_q) + CW'(1);
  assign rd_v    = inv_q[e_q];
  assign rd_sec  = sec_q[e_q];
  assign sl32    = s_q[31:0];
  assign sh32    = 32'(s_q[SW-1:32]);
  assign quot_sat = (div_quot[QBITS-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
  assign nq_diff = nq_q - NQW'(s2_q);

  assign obs_ready = (state_q == ST_IDLE);
  assign res_valid = (state_q == ST_OUT);
  assign obs_acc   = obs_i.valid && obs_ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LIM: begin
        mul_a = 32'(max_spr_q);
        mul_b = 32'(max_spr_q);
      end
      ST_RD: begin
        mul_a = rd_v;
        mul_b = rd_v;
      end
      ST_S0: begin
        mul_a = sl32;
        mul_b = sl32;
      end
      ST_S1: begin
        mul_a = sl32;
        mul_b = sh32;
      end
      ST_S2: begin
        mul_a = sh32;
        mul_b = sh32;
      end
      ST_RAD: begin
        mul_a = hint_q;
        mul_b = 32'(ratio_c);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // shared divider request
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(33'h1_0000_0000);
    div_den   = S2W'(dep_q);
    case (state_q)
      ST_RCP: begin
        div_start = 1'b1;
      end
      ST_CMP: begin
        div_start = (nq_q > NQW'(s2_q));
        div_num   = {nq_diff, 32'b0};
        div_den   = s2_q;
      end
      ST_SEL: begin
        div_start = (best_cnt_q != '0) && !amb_q && (popcount8(best_mask_q) >= msec);
        div_num   = NW'({best_cnt_q, 32'b0});
        div_den   = S2W'(best_s_q);
      end
      default: ;
    endcase
  end

  mdlh_div #(
    .NW (NW),
    .DW (S2W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sorted insert: every entry above the new value moves up one place
  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_ent
    logic gt_here, gt_below, at_end;
    assign gt_here = (32'(i) < 32'(cnt_q)) && (inv_q[i] > rcp_q);
    assign at_end  = (32'(i) == 32'(cnt_q));
    if (i > 0) begin : g_up
      assign gt_below = (32'(i - 1) < 32'(cnt_q)) && (inv_q[i-1] > rcp_q);
    end else begin : g_base
      assign gt_below = 1'b0;
    end
    always_ff @(posedge clk_i) begin
      if (state_q == ST_INS && 32'(i) <= 32'(cnt_q)) begin
        if (gt_below) begin
          inv_q[i] <= inv_q[(i > 0) ? i - 1 : 0];
          sec_q[i] <= sec_q[(i > 0) ? i - 1 : 0];
        end else if (gt_here || at_end) begin
          inv_q[i] <= rcp_q;
          sec_q[i] <= osec_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_src_q <= 5'd2;
      min_sec_q <= 4'd2;
      max_spr_q <= 16'd13;
      ratio_q   <= 15'd655;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_SOURCES:  min_src_q <= cfg_wdata_i[4:0];
        CFG_MIN_SECTORS:  min_sec_q <= cfg_wdata_i[3:0];
        CFG_MAX_SPREAD:   max_spr_q <= cfg_wdata_i;
        CFG_RADIUS_RATIO: ratio_q   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      dep_q        <= '0;
      osec_q       <= '0;
      resid_q      <= 1'b0;
      last_q       <= 1'b0;
      rcp_q        <= '0;
      n_q          <= '0;
      mp_q         <= '0;
      best_cnt_q   <= '0;
      b_q          <= '0;
      e_q          <= '0;
      best_b_q     <= '0;
      s_q          <= '0;
      best_s_q     <= '0;
      q_q          <= '0;
      mask_q       <= '0;
      best_mask_q  <= '0;
      s2_q         <= '0;
      nq_q         <= '0;
      mc_q         <= '0;
      score_q      <= '0;
      best_score_q <= '0;
      limit_q      <= '0;
      amb_q        <= 1'b0;
      status_q     <= PIX_NOT_RESIDUAL;
      hint_q       <= '0;
      rad_q        <= '0;
      srcs_q       <= '0;
      secs_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (obs_acc) begin
            dep_q   <= obs_i.obs_depth;
            osec_q  <= obs_i.obs_sector;
            resid_q <= obs_i.in_residual;
            last_q  <= obs_i.obs_last;
            if (obs_i.obs_depth != '0 && 32'(cnt_q) < MAX_SOURCES) begin
              state_q <= ST_RCP;
            end else if (obs_i.obs_last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_RCP: begin
          state_q <= ST_RCP_W;
        end
        ST_RCP_W: begin
          if (div_done) begin
            rcp_q   <= quot_sat;
            state_q <= ST_INS;
          end
        end
        ST_INS: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= last_q ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          n_q        <= cnt_q;
          cnt_q      <= '0;
          hint_q     <= '0;
          rad_q      <= '0;
          srcs_q     <= '0;
          secs_q     <= '0;
          b_q        <= '0;
          e_q        <= '0;
          s_q        <= '0;
          q_q        <= '0;
          mask_q     <= '0;
          best_cnt_q <= '0;
          amb_q      <= 1'b0;
          if (!resid_q) begin
            status_q <= PIX_NOT_RESIDUAL;
            state_q  <= ST_OUT;
          end else if (32'(cnt_q) < 32'(msrc)) begin
            status_q <= PIX_FEW_SOURCES;
            state_q  <= ST_OUT;
          end else begin
            state_q <= ST_LIM;
          end
        end
        ST_LIM: begin
          state_q <= ST_LIM_W;
        end
        ST_LIM_W: begin
          limit_q <= {prod_q[31:0], 16'b0};
          state_q <= ST_RD;
        end
        ST_RD: begin
          s_q     <= s_q + SW'(rd_v);
          mask_q  <= mask_q | (8'd1 << rd_sec);
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          q_q     <= q_q + QW'(prod_q);
          state_q <= (32'(win_cnt) < 32'(msrc)) ? ST_NEXT : ST_S0;
        end
        ST_S0: begin
          state_q <= ST_S1;
        end
        ST_S1: begin
          s2_q    <= S2W'(prod_q);
          state_q <= ST_S2;
        end
        ST_S2: begin
          s2_q    <= s2_q + (S2W'(prod_q) << 33);
          state_q <= ST_S3;
        end
        ST_S3: begin
          s2_q    <= s2_q + (S2W'(prod_q) << 64);
          mc_q    <= NQW'(q_q);
          mp_q    <= win_cnt;
          nq_q    <= '0;
          state_q <= ST_NQ;
        end
        ST_NQ: begin
          if (mp_q == '0) begin
            state_q <= ST_CMP;
          end else begin
            if (mp_q[0]) begin
              nq_q <= nq_q + mc_q;
            end
            mc_q <= mc_q << 1;
            mp_q <= mp_q >> 1;
          end
        end
        ST_CMP: begin
          if (nq_q > NQW'(s2_q)) begin
            state_q <= ST_DIV_W;
          end else begin
            score_q <= '0;
            state_q <= ST_EVAL;
          end
        end
        ST_DIV_W: begin
          if (div_done) begin
            score_q <= div_quot;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (48'(score_q) <= limit_q) begin
            if (win_cnt > best_cnt_q ||
                (win_cnt == best_cnt_q && score_q < best_score_q)) begin
              amb_q        <= 1'b0;
              best_b_q     <= b_q;
              best_cnt_q   <= win_cnt;
              best_score_q <= score_q;
              best_s_q     <= s_q;
              best_mask_q  <= mask_q;
            end else if (win_cnt == best_cnt_q && score_q == best_score_q &&
                         b_q != best_b_q) begin
              amb_q <= 1'b1;
            end
          end
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          if (32'(e_q) + 32'd1 < 32'(n_q)) begin
            e_q     <= e_q + IW'(1);
            state_q <= ST_RD;
          end else if (32'(b_q) + 32'd1 < 32'(n_q)) begin
            b_q     <= b_q + IW'(1);
            e_q     <= b_q + IW'(1);
            s_q     <= '0;
            q_q     <= '0;
            mask_q  <= '0;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (best_cnt_q == '0 || amb_q) begin
            status_q <= PIX_SPREAD_REJ;
            state_q  <= ST_OUT;
          end else if (popcount8(best_mask_q) < msec) begin
            status_q <= PIX_FEW_SECTORS;
            state_q  <= ST_OUT;
          end else begin
            state_q <= ST_HNT_W;
          end
        end
        ST_HNT_W: begin
          if (div_done) begin
            hint_q  <= quot_sat;
            state_q <= ST_RAD;
          end
        end
        ST_RAD: begin
          state_q <= ST_RAD_W;
        end
        ST_RAD_W: begin
          rad_q    <= prod_q[47:16];
          status_q <= PIX_COVERED;
          srcs_q   <= 5'(best_cnt_q);
          secs_q   <= popcount8(best_mask_q);
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (res_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign obs_i.ready         = obs_ready;
  assign res_o.valid         = res_valid;
  assign res_o.pixel_status  = status_q;
  assign res_o.hint_depth    = hint_q;
  assign res_o.hint_radius   = rad_q;
  assign res_o.layer_sources = srcs_q;
  assign res_o.layer_sectors = secs_q;

  `MDLH_ASSERT(a_hs_excl, !(obs_ready && res_valid), "input and result both open")
  `MDLH_ASSERT(a_cnt_max, 32'(cnt_q) <= MAX_SOURCES, "observation count overflow")
  `MDLH_ASSERT(a_zero_fields, (res_valid && status_q != PIX_COVERED) |-> (hint_q == '0 && rad_q == '0 && srcs_q == '0 && secs_q == '0), "fields set on uncovered pixel")
  `MDLH_ASSERT_NEXT(a_ret_idle, res_valid && res_o.ready, obs_ready && cnt_q == '0, "not idle after result")

endmodule
